### rtl/bzs_pkg.sv
// Shared types and constants for the Bezier subdivision block.
package bzs_pkg;

  localparam int COEF_W = 32;
  localparam int IDX_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

  // One completed set handed from front to back.
  typedef struct packed {
    logic              err;
    logic [IDX_W-1:0]  ord;
    logic signed [COEF_W-1:0] t_cl;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } bzs_job_t;

endpackage

### rtl/bzs_front.sv
// Front part: loads coefficients, clamps t and issues one job per set.
module bzs_front #(
  parameter int MAX_ORDER = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  logic signed [bzs_pkg::COEF_W-1:0] coef_in,
  input  logic signed [bzs_pkg::COEF_W-1:0] param_t,
  input  logic [bzs_pkg::IDX_W-1:0] order_q,
  input  logic signed [bzs_pkg::COEF_W-1:0] start_q,
  input  logic signed [bzs_pkg::COEF_W-1:0] end_q,
  output logic job_valid,
  input  logic job_ready,
  output bzs_pkg::bzs_job_t job,
  output logic st_we,
  output logic [$clog2(MAX_ORDER)-1:0] st_waddr,
  output logic signed [bzs_pkg::COEF_W-1:0] st_wdata
);
  import bzs_pkg::*;
  localparam int AW = $clog2(MAX_ORDER);

  logic [IDX_W-1:0] load_count_r, load_count_nxt;
  logic [IDX_W-1:0] k;
  logic signed [COEF_W-1:0] t_cl;
  logic acc, done;

  always_comb begin
    k = order_q;
    if (k == '0) k = IDX_W'(1);
    if ({1'b0, k} > (IDX_W+1)'(MAX_ORDER)) k = IDX_W'(MAX_ORDER);
  end

  // Coefficient store is shared with the back part; only load while no job waits.
  assign full = job_valid && !job_ready;
  assign acc  = push && !full;
  assign load_count_nxt = load_count_r + IDX_W'(1);
  assign done = acc && (load_count_nxt >= k);

  assign st_we    = acc;
  assign st_waddr = load_count_r[AW-1:0];
  assign st_wdata = coef_in;

  always_comb begin
    t_cl = param_t;
    if (t_cl < start_q) t_cl = start_q;
    if (t_cl > end_q) t_cl = end_q;
  end

  // Hold the job until the back part takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      job_valid    <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (acc) load_count_r <= done ? '0 : load_count_nxt;
      if (done) begin
        job_valid <= 1'b1;
        job.err   <= (start_q >= end_q);
        job.ord   <= k;
        job.t_cl  <= t_cl;
        job.a     <= start_q;
        job.b     <= end_q;
      end
    end
  end
endmodule

### rtl/bzs_back.sv
// Back part: alpha division, de Casteljau lerps and result queue.
module bzs_back #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  bzs_pkg::bzs_job_t job,
  input  logic st_we,
  input  logic [$clog2(MAX_ORDER)-1:0] st_waddr,
  input  logic signed [bzs_pkg::COEF_W-1:0] st_wdata,
  output logic empty,
  input  logic pop,
  output logic signed [bzs_pkg::COEF_W-1:0] coef_out,
  output logic [bzs_pkg::IDX_W-1:0] out_index,
  output logic status,
  output logic last_flag
);
  import bzs_pkg::*;
  localparam int AW  = $clog2(MAX_ORDER);
  localparam int AL_W = FRAC_BITS + 1;
  localparam int NW  = 33 + FRAC_BITS;
  localparam int PW  = COEF_W + AL_W + 2;
  localparam int SW  = $clog2(NW + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_LERP = 3'd2,
                         S_EMIT = 3'd3, S_ERR = 3'd4;

  logic signed [COEF_W-1:0] coef_store_r [MAX_ORDER];
  logic signed [COEF_W-1:0] work_row_r   [MAX_ORDER];
  logic signed [COEF_W-1:0] right_store_r[MAX_ORDER];

  logic [2:0] state_r;
  bzs_job_t   job_r;
  logic [NW-1:0] num_r, rem_r;
  logic [32:0]   den_r;
  logic [SW-1:0] dcnt_r;
  logic [AL_W-1:0] alpha_r;
  logic [IDX_W-1:0] row_r, col_r, pos_r;
  logic out_v_r;
  logic signed [COEF_W-1:0] coef_out_r;
  logic [IDX_W-1:0] idx_out_r;
  logic st_out_r, last_out_r;

  logic [NW:0] rem_sh;
  logic [AL_W-1:0] q_nxt;
  logic signed [PW-1:0] one_s, al_s, s;
  logic signed [COEF_W-1:0] lr;
  logic slot_free;

  assign job_ready = (state_r == S_IDLE);
  assign slot_free = !out_v_r || pop;

  // Restoring divide, one quotient bit per cycle.
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign q_nxt  = {alpha_r[AL_W-2:0], (rem_sh >= {{(NW-32){1'b0}}, den_r})};

  // Lerp of work_row[col-1] and work_row[col].
  always_comb begin
    one_s = PW'(1) <<< FRAC_BITS;
    al_s  = PW'({1'b0, alpha_r});
    s = al_s * PW'(work_row_r[col_r[AW-1:0] - AW'(1)])
      + (one_s - al_s) * PW'(work_row_r[col_r[AW-1:0]])
      + (one_s >>> 1);
    lr = COEF_W'(s >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (st_we) coef_store_r[st_waddr] <= st_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (pop && out_v_r) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            // Snapshot the set before the front part reuses the store.
            for (int i = 0; i < MAX_ORDER; i++) work_row_r[i] <= coef_store_r[i];
            right_store_r[job.ord[AW-1:0] - AW'(1)] <=
              coef_store_r[job.ord[AW-1:0] - AW'(1)];
            if (job.err) state_r <= S_ERR;
            else begin
              num_r  <= {1'b0, COEF_W'(job.b - job.t_cl), FRAC_BITS'(0)}
                        + NW'({1'b0, COEF_W'(job.b - job.a)} >> 1);
              den_r  <= {1'b0, COEF_W'(job.b - job.a)};
              rem_r  <= '0;
              alpha_r <= '0;
              dcnt_r <= SW'(NW);
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r   <= (rem_sh >= {{(NW-32){1'b0}}, den_r}) ?
                     NW'(rem_sh - {{(NW-32){1'b0}}, den_r}) : NW'(rem_sh);
          num_r   <= num_r << 1;
          alpha_r <= q_nxt;
          dcnt_r  <= dcnt_r - SW'(1);
          if (dcnt_r == SW'(1)) begin
            row_r <= IDX_W'(1);
            col_r <= job_r.ord - IDX_W'(1);
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          if (row_r >= job_r.ord) state_r <= S_EMIT;
          else begin
            work_row_r[col_r[AW-1:0]] <= lr;
            if (col_r == row_r) begin
              if (col_r == job_r.ord - IDX_W'(1))
                right_store_r[job_r.ord[AW-1:0] - AW'(1) - row_r[AW-1:0]] <= lr;
              row_r <= row_r + IDX_W'(1);
              col_r <= job_r.ord - IDX_W'(1);
            end else if (col_r == job_r.ord - IDX_W'(1)) begin
              right_store_r[job_r.ord[AW-1:0] - AW'(1) - row_r[AW-1:0]] <= lr;
              col_r <= col_r - IDX_W'(1);
            end else col_r <= col_r - IDX_W'(1);
          end
          pos_r <= '0;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_v_r    <= 1'b1;
            idx_out_r  <= pos_r;
            st_out_r   <= 1'b0;
            last_out_r <= (pos_r == {job_r.ord[IDX_W-2:0], 1'b0} - IDX_W'(1));
            coef_out_r <= (pos_r < job_r.ord) ? work_row_r[pos_r[AW-1:0]]
                          : right_store_r[AW'(pos_r - job_r.ord)];
            if (pos_r == {job_r.ord[IDX_W-2:0], 1'b0} - IDX_W'(1)) state_r <= S_IDLE;
            pos_r <= pos_r + IDX_W'(1);
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_v_r <= 1'b1;
            idx_out_r <= '0;
            st_out_r <= 1'b1;
            last_out_r <= 1'b1;
            coef_out_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign empty     = !out_v_r;
  assign coef_out  = coef_out_r;
  assign out_index = idx_out_r;
  assign status    = st_out_r;
  assign last_flag = last_out_r;
endmodule

### rtl/bezier_subdivide_top.sv
// Top level of the Bezier subdivision block.
// Usage: push order coefficients (in_coef_in) one per transaction; with the
// last one, in_param_t gives the split point, clamped to [start, end].
// An item is taken when in_push is high and in_full low. Results appear as a
// queue: while out_empty is low the oldest result is shown; out_pop takes it.
// A complete set yields 2*order results (left set, then right set) or a
// single status-1 result when start >= end.
// After the last coefficient the job is handed to the back part, the
// bit-serial alpha divider runs, then the lerps run on one shared
// multiply-add; results then follow one per cycle while out_pop keeps up.
// Throughput: one set at a time; the divider and lerp unit set the rate.
// Coefficients of the next set load while the current set is computed.
// A stalled receiver holds the one-entry result register and the sequencer.
// Reset (rst_n low, synchronous) clears counts and control; config returns
// to order 4, interval [0, 1.0]. The user must write config only while idle,
// through cfg_we/cfg_index/cfg_data; the block itself does not enforce it.
module bezier_subdivide_top #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic signed [bzs_pkg::COEF_W-1:0] in_coef_in,
  input  logic signed [bzs_pkg::COEF_W-1:0] in_param_t,
  output logic out_empty,
  input  logic out_pop,
  output logic signed [bzs_pkg::COEF_W-1:0] out_coef_out,
  output logic [bzs_pkg::IDX_W-1:0] out_out_index,
  output logic out_status,
  output logic out_last_flag,
  input  logic cfg_we,
  input  logic [bzs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bzs_pkg::COEF_W-1:0] cfg_data
);
  import bzs_pkg::*;
  localparam int AW = $clog2(MAX_ORDER);

  logic [IDX_W-1:0] order_r;
  logic signed [COEF_W-1:0] start_r, end_r;
  logic job_valid, job_ready, st_we;
  bzs_job_t job;
  logic [AW-1:0] st_waddr;
  logic signed [COEF_W-1:0] st_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= IDX_W'(4);
      start_r <= '0;
      end_r   <= COEF_W'(32'sd65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER: order_r <= cfg_data[IDX_W-1:0];
        REG_START: start_r <= cfg_data;
        REG_END:   end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  bzs_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk, .rst_n, .push(in_push), .full(in_full),
    .coef_in(in_coef_in), .param_t(in_param_t),
    .order_q(order_r), .start_q(start_r), .end_q(end_r),
    .job_valid, .job_ready, .job, .st_we, .st_waddr, .st_wdata
  );

  bzs_back #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .st_we, .st_waddr, .st_wdata,
    .empty(out_empty), .pop(out_pop), .coef_out(out_coef_out),
    .out_index(out_out_index), .status(out_status), .last_flag(out_last_flag)
  );
endmodule

### rtl/bzs_checker.sv
// Port-level checks for the Bezier subdivision block, bound to the top.
module bzs_checker (
  input logic clk,
  input logic rst_n,
  input logic out_empty,
  input logic out_pop,
  input logic out_status,
  input logic out_last_flag,
  input logic [3:0] out_out_index
);
  // An error result is always a lone last result at index zero.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |-> (out_last_flag && out_out_index == 4'd0))
    else $error("error result malformed");
  // A held result stays while not popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped");
  // Reset empties the result side.
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("not empty after reset");
endmodule

bind bezier_subdivide_top bzs_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_status, .out_last_flag, .out_out_index
);

### tb/sv/tb_top.sv
// Self-checking testbench for the Bezier subdivision block.
module tb_top;
  import bzs_pkg::*;

  localparam int  CLK_HALF   = 6;
  localparam int  MAXO       = 8;
  localparam int  DRAIN_CYC  = 120;
  localparam longint CYC_LIMIT = 400000;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic signed [COEF_W-1:0] t;
  } load_item_t;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [IDX_W-1:0]         idx;
    logic                     status;
    logic                     last;
  } seg_res_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [COEF_W-1:0] in_coef_in;
  logic signed [COEF_W-1:0] in_param_t;
  logic out_empty;
  logic out_pop;
  logic signed [COEF_W-1:0] out_coef_out;
  logic [IDX_W-1:0] out_out_index;
  logic out_status;
  logic out_last_flag;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  bezier_subdivide_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_coef_in(in_coef_in), .in_param_t(in_param_t),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_coef_out(out_coef_out), .out_out_index(out_out_index),
    .out_status(out_status), .out_last_flag(out_last_flag),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  load_item_t load_q[$];
  seg_res_t   seg_exp_q[$];
  int         send_idle_pct;
  int         pop_stall_pct;
  bit         failed;
  longint     cyc;

  // predictor state
  logic [3:0]               m_order;
  logic signed [COEF_W-1:0] m_start;
  logic signed [COEF_W-1:0] m_end;
  logic signed [COEF_W-1:0] m_store[MAXO];
  logic [3:0]               m_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // alpha*x + (1-alpha)*y, round to nearest, ties toward +inf
  function automatic longint blend(longint x, longint y, longint al);
    longint s;
    s = al * x + (65536 - al) * y + 32768;
    if (s >= 0) return s >>> 16;
    return -((-s + 65535) >>> 16);
  endfunction

  function automatic void push_seg(longint c, int idx, bit st, bit lst);
    seg_res_t r;
    r.coef   = c[31:0];
    r.idx    = idx[3:0];
    r.status = st;
    r.last   = lst;
    seg_exp_q.push_back(r);
  endfunction

  // absorb one coefficient; a full set queues the subdivided sets or an error result
  function automatic void subdivide_absorb(load_item_t it);
    int k;
    longint a, b, t, den, alpha;
    longint row[MAXO];
    longint rgt[MAXO];
    k = (m_order == 0) ? 1 : (m_order > MAXO) ? MAXO : int'(m_order);
    m_store[m_count % MAXO] = it.coef;
    m_count = m_count + 4'd1;
    if (m_count < k) return;
    m_count = 0;
    a = m_start;
    b = m_end;
    if (a >= b) begin
      push_seg(0, 0, 1'b1, 1'b1);
      return;
    end
    t = it.t;
    if (t < a) t = a;
    if (t > b) t = b;
    den = b - a;
    alpha = (((b - t) << 16) + (den >> 1)) / den;
    for (int j = 0; j < k; j++) row[j] = m_store[j];
    push_seg(row[0], 0, 1'b0, 1'b0);
    rgt[k-1] = row[k-1];
    for (int r = 1; r < k; r++) begin
      for (int j = k - 1; j >= r; j--) row[j] = blend(row[j-1], row[j], alpha);
      push_seg(row[r], r, 1'b0, 1'b0);
      rgt[k-1-r] = row[k-1];
    end
    for (int r = 0; r < k; r++) push_seg(rgt[r], k + r, 1'b0, r == k - 1);
  endfunction

  // input driver: retire accepted transaction, then present the next one
  always @(posedge clk) begin
    bit nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) subdivide_absorb(load_q.pop_front());
      nxt = (load_q.size() > 0) && ($urandom_range(99) >= send_idle_pct);
      in_push <= nxt;
      if (nxt) begin
        in_coef_in <= load_q[0].coef;
        in_param_t <= load_q[0].t;
      end
    end
  end

  // result monitor: compare each popped transaction with the oldest expectation
  always @(posedge clk) begin
    seg_res_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (seg_exp_q.size() == 0) begin
          $display("%0t unexpected result: coef %h idx %0d status %0b last %0b", $time,
                   out_coef_out, out_out_index, out_status, out_last_flag);
          failed = 1'b1;
        end else begin
          e = seg_exp_q.pop_front();
          if (out_coef_out !== e.coef) begin
            $display("%0t coef mismatch: expected %h actual %h", $time, e.coef, out_coef_out);
            failed = 1'b1;
          end
          if (out_out_index !== e.idx) begin
            $display("%0t index mismatch: expected %0d actual %0d", $time, e.idx,
                     out_out_index);
            failed = 1'b1;
          end
          if (out_status !== e.status) begin
            $display("%0t status mismatch: expected %0b actual %0b", $time, e.status,
                     out_status);
            failed = 1'b1;
          end
          if (out_last_flag !== e.last) begin
            $display("%0t last mismatch: expected %0b actual %0b", $time, e.last,
                     out_last_flag);
            failed = 1'b1;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ORDER: m_order = val[3:0];
      REG_START: m_start = val;
      REG_END:   m_end   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int ord, logic [31:0] a, logic [31:0] b);
    write_reg(REG_ORDER, ord);
    write_reg(REG_START, a);
    write_reg(REG_END, b);
  endtask

  // hold until all input is taken and results are back, then let the block settle
  task automatic drain();
    while (load_q.size() > 0 || in_push || seg_exp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic add_item(logic [31:0] c, logic [31:0] t);
    load_item_t it;
    it.coef = c;
    it.t    = t;
    load_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // t mostly inside the interval, sometimes anywhere
  function automatic logic [31:0] rand_t();
    longint a, b;
    a = m_start;
    b = m_end;
    if (a >= b || $urandom_range(3) == 0) return $urandom;
    return a + ({$urandom, $urandom} % (b - a + 1));
  endfunction

  task automatic set_profile(int p);
    case (p % 4)
      0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      1: begin send_idle_pct = 72; pop_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct = 72; end
      default: begin send_idle_pct = 22; pop_stall_pct = 22; end
    endcase
  endtask

  initial begin
    int n, k;
    logic [31:0] a, b;
    failed = 1'b0;
    cyc = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_coef_in = '0;
    in_param_t = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ORDER;
    cfg_data = '0;
    m_order = 4;
    m_start = 0;
    m_end = 32'h00010000;
    m_count = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: midpoint split, t below and above the interval
    add_item(32'h7fffffff, 0); add_item(32'h80000000, 0);
    add_item(0, 0);            add_item(1, 32'h00008000);
    add_item(32'hffffffff, 0); add_item(32'h00010000, 0);
    add_item(32'h80000000, 0); add_item(32'h7fffffff, 32'hfffffffb);
    add_item($urandom, 0);     add_item($urandom, 0);
    add_item($urandom, 0);     add_item($urandom, 32'h7fffffff);
    drain();

    // order 1 over the widest interval, t at both ends
    set_config(1, 32'h80000000, 32'h7fffffff);
    add_item(32'h12345678, 32'h80000000);
    add_item(32'h87654321, 32'h7fffffff);
    drain();

    // order zero acts as one; order fifteen saturates to eight
    set_config(0, 32'hffff0000, 32'h00030000);
    add_item(32'h00020000, 32'h00010000);
    drain();
    set_config(15, 32'hffff0000, 32'h00030000);
    for (int i = 0; i < 8; i++) add_item(rand_coef(), 32'h00004000);
    drain();

    // empty and reversed intervals
    set_config(2, 32'h00020000, 32'h00020000);
    add_item(5, 0); add_item(6, 0);
    drain();
    set_config(1, 32'h7fffffff, 32'h80000000);
    add_item(7, 0);
    drain();

    // order lowered while a set is partly loaded
    set_config(5, 0, 32'h00010000);
    add_item(32'h00010000, 0); add_item(32'h00020000, 0); add_item(32'h00030000, 0);
    drain();
    set_config(2, 0, 32'h00010000);
    add_item(32'h00040000, 32'h00008000);
    drain();

    // random phases
    for (int p = 0; p < 8; p++) begin
      set_profile(p);
      if (p == 0) k = MAXO;
      else if ($urandom_range(9) == 0) k = $urandom_range(15);
      else k = $urandom_range(4, 1);
      case ($urandom_range(7))
        0: begin a = $urandom; b = a; end
        1: begin a = $urandom_range(1000); b = a - $urandom_range(1000); end
        2: begin a = 32'h80000000; b = 32'h7fffffff; end
        3: begin a = $urandom; b = $urandom; end
        default: begin
          a = $urandom_range(65536 * 8) - 65536 * 4;
          b = a + $urandom_range(65536 * 4, 1);
        end
      endcase
      set_config(k, a, b);
      n = 0;
      while (n < 18) begin
        add_item(rand_coef(), rand_t());
        n++;
      end
      drain();
    end

    if (!failed && seg_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
